>>> sv/mlp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mlp_pkg;

  localparam int HIDDEN_COUNT_DEF = 25;
  localparam int FRAC_BITS_DEF = 16;
  localparam int ROM_NEURONS = 25;
  localparam int FIELD_W = 19;
  localparam longint MICRO = 64'sd1000000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_HID,
    ST_SEG,
    ST_ACT1,
    ST_ACT2,
    ST_OUT,
    ST_FINAL,
    ST_DONE
  } state_t;

  typedef longint lint3_t [3];
  typedef longint lint4_t [4];
  typedef longint lint5_t [5];
  typedef longint lint25_t [25];
  typedef longint lint75_t [75];

  localparam lint75_t W_HID_MICRO = '{
    -4162388, 730794, -2431392, -4896474, -328038, -2967811, 1491192,
    -7031680, 601389, 861134, 387004, 396748, 1329492, -6544066, 597795, -987176, -418131,
    -432930, -2305198, 3389106, -1554975, -51860, -6302748, -308038, 5260182, 583164,
    3266499, -55235, -6267354, -362831, 406702, 1341032, 324966, 1486634, -3847890, 911256,
    -636496, 1644910, -392827, 3083439, -1123031, 2217883, 4447189, -249650, 2633869,
    3157065, -1154619, 2283502, 841558, 743843, 328180, 585216, -1517525, 361929, 370214,
    -1098692, 235458, -2146381, 3422277, -1429814, -591178, -1215725, 192546, 45723, 39730,
    -155519, -735572, -44603, -297243, -597163, -1144104, 210976, -1247404, -365307,
    -533001};
  localparam lint25_t B_HID_MICRO = '{
    3482459, 3462489, -8320638, -311914, -8147101, 25243, 4466108, -7258114,
    -3622175, -7111324, 1610289, -3278108, 959782, -2365794, -3429868, -2415060, 899197,
    -1038448, -1634513, 4398274, -1716122, -349988, 736048, -1690931, 868819};
  localparam lint25_t W_OUT_MICRO = '{
    1926091, 7352876, -3006100, 4036904, 8274290, 3102197, 4954952, -7802333,
    3583243, 5224246, -214347, 176114, 3282575, 1813378, 5282540, -1647750, -456200,
    6356190, -11786261, -6196810, 1649847, 5417224, -4702090, -1643533, 3414399};
  localparam longint B_OUT_MICRO = -404523;
  localparam lint3_t IN_LO_MICRO = '{750500000, 2838927, 263000000};
  localparam lint3_t IN_HI_MICRO = '{1578800000, 569413700, 363000000};
  localparam longint OUT_LO_MICRO = 782160000;
  localparam longint OUT_HI_MICRO = 1403600000;
  localparam lint3_t REC_MICRO = '{
    2 * MICRO * MICRO / (IN_HI_MICRO[0] - IN_LO_MICRO[0]),
    2 * MICRO * MICRO / (IN_HI_MICRO[1] - IN_LO_MICRO[1]),
    2 * MICRO * MICRO / (IN_HI_MICRO[2] - IN_LO_MICRO[2])};
  localparam longint SCALE_MICRO = (OUT_HI_MICRO - OUT_LO_MICRO) / 2;
  localparam lint5_t C1_MICRO = '{-302600, -255000, -70610, -15230, -3117};
  localparam lint5_t C2_MICRO = '{1082000, 927500, 357300, 100900, 25630};
  localparam lint5_t C3_MICRO = '{-4793, 87850, 532000, 829400, 946700};
  localparam lint4_t BND_MICRO = '{800000, 1600000, 2400000, 3200000};
  localparam longint FOUR_MICRO = 4 * MICRO;

  function automatic longint to_fix(longint m, int frac);
    longint n;
    n = m * (64'sd1 <<< frac);
    if (n >= 0) begin
      return (n + MICRO / 2) / MICRO;
    end
    return -((-n + MICRO / 2) / MICRO);
  endfunction

  function automatic lint3_t fix3(lint3_t m, int frac);
    lint3_t r;
    for (int i = 0; i < 3; i++) r[i] = to_fix(m[i], frac);
    return r;
  endfunction

  function automatic lint4_t fix4(lint4_t m, int frac);
    lint4_t r;
    for (int i = 0; i < 4; i++) r[i] = to_fix(m[i], frac);
    return r;
  endfunction

  function automatic lint5_t fix5(lint5_t m, int frac);
    lint5_t r;
    for (int i = 0; i < 5; i++) r[i] = to_fix(m[i], frac);
    return r;
  endfunction

  function automatic lint25_t fix25(lint25_t m, int frac);
    lint25_t r;
    for (int i = 0; i < 25; i++) r[i] = to_fix(m[i], frac);
    return r;
  endfunction

  function automatic lint75_t fix75(lint75_t m, int frac);
    lint75_t r;
    for (int i = 0; i < 75; i++) r[i] = to_fix(m[i], frac);
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/mlp_smul.sv
`timescale 1ns / 1ps
`default_nettype none

module mlp_smul #(
  parameter int AW = 28,
  parameter int BW = 25
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic signed [AW-1:0]    a,
  input  wire logic signed [BW-1:0]    b,
  output logic                         done,
  output logic signed [AW+BW-1:0]      prod
);

  localparam int HW = AW + 2;
  localparam int CW = $clog2(BW + 1);

  logic signed [AW-1:0] a_r;
  logic signed [HW-1:0] hi_r, hi_nxt;
  logic [BW-1:0]        lo_r, lo_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic signed [HW-1:0] addend;
  logic signed [HW-1:0] t;
  logic                 last;

  always_comb begin
    last = (cnt_r == CW'(BW - 1));
    if (!lo_r[0]) begin
      addend = '0;
    end else if (last) begin
      addend = -HW'(a_r);
    end else begin
      addend = HW'(a_r);
    end
    t = hi_r + addend;
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      hi_nxt = '0;
      lo_nxt = b;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      hi_nxt = {t[HW-1], t[HW-1:1]};
      lo_nxt = {t[0], lo_r[BW-1:1]};
      cnt_nxt = cnt_r + CW'(1);
      if (last) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    hi_r <= hi_nxt;
    lo_r <= lo_nxt;
    if (start) begin
      a_r <= a;
    end
  end

  assign done = done_r;
  assign prod = {hi_r[AW-1:0], lo_r};

endmodule

`default_nettype wire

>>> sv/mlp_3_25_1_tanh_approx.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake            Fields
// in_      input      in_valid / in_stall   in_meas_first, in_meas_second, in_meas_third
// out_     output     out_valid / out_stall out_predicted_value
//
// All arithmetic runs through one bit-serial multiplier that retires one multiplier
// bit per cycle. One item needs up to 4 + 6 * HiddenCount products, fewer when a
// hidden sum skips the activation polynomial, with HiddenCount capped at 25 neurons;
// one item is in work at a time.
// Reset is synchronous and clears the sequencer, the multiplier and the output valid flag.
// A new beat is taken whenever the sequencer is idle, even while a result waits.

module mlp_3_25_1_tanh_approx #(
  parameter int HiddenCount = mlp_pkg::HIDDEN_COUNT_DEF,
  parameter int InternalFracBits = mlp_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [18:0] in_meas_first,
  input  wire logic [18:0] in_meas_second,
  input  wire logic [18:0] in_meas_third,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [18:0]      out_predicted_value
);

  localparam int F = InternalFracBits;
  localparam int VW = F + 8;
  localparam int MA = F + 12;
  localparam int MB = F + 9;
  localparam int PW = MA + MB;
  localparam int RW = PW - F;
  localparam int SW = RW + 1;
  localparam int FW = mlp_pkg::FIELD_W;

  localparam longint ONE = 64'sd1 <<< F;
  localparam longint SAT_HI = (64'sd1 <<< (F + 7)) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< (F + 7));
  localparam longint HALF = 64'sd1 <<< (F - 1);
  localparam longint YHALF = 64'sd1 <<< (F - 9);
  localparam longint FIELD_MAX = (64'sd1 <<< FW) - 1;

  localparam mlp_pkg::lint3_t RECF = mlp_pkg::fix3(mlp_pkg::REC_MICRO, F);
  localparam mlp_pkg::lint3_t LOF = mlp_pkg::fix3(mlp_pkg::IN_LO_MICRO, F);
  localparam mlp_pkg::lint75_t WHF = mlp_pkg::fix75(mlp_pkg::W_HID_MICRO, F);
  localparam mlp_pkg::lint25_t BHF = mlp_pkg::fix25(mlp_pkg::B_HID_MICRO, F);
  localparam mlp_pkg::lint25_t WOF = mlp_pkg::fix25(mlp_pkg::W_OUT_MICRO, F);
  localparam mlp_pkg::lint5_t C1F = mlp_pkg::fix5(mlp_pkg::C1_MICRO, F);
  localparam mlp_pkg::lint5_t C2F = mlp_pkg::fix5(mlp_pkg::C2_MICRO, F);
  localparam mlp_pkg::lint5_t C3F = mlp_pkg::fix5(mlp_pkg::C3_MICRO, F);
  localparam mlp_pkg::lint4_t BNDF = mlp_pkg::fix4(mlp_pkg::BND_MICRO, F);
  localparam longint FOURF = mlp_pkg::to_fix(mlp_pkg::FOUR_MICRO, F);
  localparam longint BOUTF = mlp_pkg::to_fix(mlp_pkg::B_OUT_MICRO, F);
  localparam longint SCALEF = mlp_pkg::to_fix(mlp_pkg::SCALE_MICRO, F);
  localparam longint OFFF = mlp_pkg::to_fix(mlp_pkg::OUT_LO_MICRO, F);
  localparam int LASTN = (HiddenCount < mlp_pkg::ROM_NEURONS) ? HiddenCount - 1
                                                             : mlp_pkg::ROM_NEURONS - 1;

  function automatic logic signed [VW-1:0] sat_f(logic signed [SW-1:0] v);
    if (v > SW'(SAT_HI)) begin
      return VW'(SAT_HI);
    end
    if (v < SW'(SAT_LO)) begin
      return VW'(SAT_LO);
    end
    return VW'(v);
  endfunction

  mlp_pkg::state_t state_r, state_nxt;

  logic [FW-1:0]        raw_r [3];
  logic signed [VW-1:0] x_r [3];
  logic signed [VW-1:0] s_r;
  logic signed [VW-1:0] r_r;
  logic signed [VW-1:0] acc_r;
  logic [VW-1:0]        a_r;
  logic [2:0]           k_r;
  logic                 neg_r;
  logic [1:0]           jj_r;
  logic [4:0]           ni_r;
  logic [6:0]           widx_r;
  logic                 run_r;
  logic                 out_valid_r;
  logic [FW-1:0]        out_val_r;
  logic [FW-1:0]        y_r;

  logic                 mul_start;
  logic                 mul_done;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] prod_h;
  logic signed [RW-1:0] pr;
  logic signed [MA-1:0] raw_ext;

  logic signed [VW:0]   s_abs;
  logic [VW-1:0]        a_new;
  logic [2:0]           k_new;
  logic signed [VW-1:0] poly_val;
  logic signed [SW-1:0] y_full;
  logic signed [SW-1:0] y_sh;
  logic [FW-1:0]        y_clamp;

  mlp_smul #(.AW(MA), .BW(MB)) u_smul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  always_comb begin
    prod_h = prod + PW'(HALF);
    pr = RW'(prod_h >>> F);
    raw_ext = $signed({{(MA - FW){1'b0}}, raw_r[jj_r]}) <<< (F - 8);
    s_abs = s_r[VW-1] ? -(VW + 1)'(s_r) : (VW + 1)'(s_r);
    a_new = s_abs[VW-1:0];
    k_new = '0;
    for (int i = 0; i < 4; i++) begin
      if ({1'b0, a_new} >= (VW + 1)'(BNDF[i])) begin
        k_new = 3'(i + 1);
      end
    end
    poly_val = sat_f(SW'(pr) + SW'(C3F[k_r]));
    y_full = SW'(pr) + SW'(OFFF);
    y_sh = (y_full + SW'(YHALF)) >>> (F - 8);
    if (y_sh < 0) begin
      y_clamp = '0;
    end else if (y_sh > SW'(FIELD_MAX)) begin
      y_clamp = FW'(FIELD_MAX);
    end else begin
      y_clamp = FW'(y_sh);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mlp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mlp_pkg::ST_NORM;
      end
      mlp_pkg::ST_NORM: begin
        if (mul_done && jj_r == 2'd2) state_nxt = mlp_pkg::ST_HID;
      end
      mlp_pkg::ST_HID: begin
        if (mul_done && jj_r == 2'd2) state_nxt = mlp_pkg::ST_SEG;
      end
      mlp_pkg::ST_SEG: begin
        if ({1'b0, a_new} >= (VW + 1)'(FOURF)) begin
          state_nxt = mlp_pkg::ST_OUT;
        end else begin
          state_nxt = mlp_pkg::ST_ACT1;
        end
      end
      mlp_pkg::ST_ACT1: begin
        if (mul_done) state_nxt = mlp_pkg::ST_ACT2;
      end
      mlp_pkg::ST_ACT2: begin
        if (mul_done) state_nxt = mlp_pkg::ST_OUT;
      end
      mlp_pkg::ST_OUT: begin
        if (mul_done) begin
          state_nxt = (ni_r == 5'(LASTN)) ? mlp_pkg::ST_FINAL : mlp_pkg::ST_HID;
        end
      end
      mlp_pkg::ST_FINAL: begin
        if (mul_done) state_nxt = mlp_pkg::ST_DONE;
      end
      mlp_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) state_nxt = mlp_pkg::ST_IDLE;
      end
      default: state_nxt = mlp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a = '0;
    mul_b = '0;
    in_stall = 1'b1;
    unique case (state_r) inside
      mlp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
      end
      mlp_pkg::ST_NORM: begin
        mul_start = !run_r;
        mul_a = raw_ext - MA'(LOF[jj_r]);
        mul_b = MB'(RECF[jj_r]);
      end
      mlp_pkg::ST_HID: begin
        mul_start = !run_r;
        mul_a = MA'(x_r[jj_r]);
        mul_b = MB'(WHF[widx_r]);
      end
      mlp_pkg::ST_ACT1: begin
        mul_start = !run_r;
        mul_a = MA'(C1F[k_r]);
        mul_b = $signed({1'b0, a_r});
      end
      mlp_pkg::ST_ACT2: begin
        mul_start = !run_r;
        mul_a = MA'(r_r);
        mul_b = $signed({1'b0, a_r});
      end
      mlp_pkg::ST_OUT: begin
        mul_start = !run_r;
        mul_a = MA'(r_r);
        mul_b = MB'(WOF[ni_r]);
      end
      mlp_pkg::ST_FINAL: begin
        mul_start = !run_r;
        mul_a = MA'(SCALEF);
        mul_b = MB'(acc_r) + MB'(ONE);
      end
      mlp_pkg::ST_SEG, mlp_pkg::ST_DONE: begin
        mul_start = 1'b0;
      end
      default: mul_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mlp_pkg::ST_IDLE;
      run_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (mul_start) begin
        run_r <= 1'b1;
      end else if (mul_done) begin
        run_r <= 1'b0;
      end
      if (state_r == mlp_pkg::ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end

    if (state_r == mlp_pkg::ST_DONE && (!out_valid_r || !out_stall)) begin
      out_val_r <= y_r;
    end

    case (state_r)
      mlp_pkg::ST_IDLE: begin
        raw_r[0] <= in_meas_first;
        raw_r[1] <= in_meas_second;
        raw_r[2] <= in_meas_third;
        jj_r <= '0;
      end
      mlp_pkg::ST_NORM: begin
        if (mul_done) begin
          x_r[jj_r] <= sat_f(SW'(pr) - SW'(ONE));
          if (jj_r == 2'd2) begin
            jj_r <= '0;
            ni_r <= '0;
            widx_r <= '0;
            s_r <= VW'(BHF[0]);
            acc_r <= VW'(BOUTF);
          end else begin
            jj_r <= jj_r + 2'd1;
          end
        end
      end
      mlp_pkg::ST_HID: begin
        if (mul_done) begin
          s_r <= sat_f(SW'(s_r) + SW'(pr));
          widx_r <= widx_r + 7'd1;
          jj_r <= (jj_r == 2'd2) ? 2'd0 : jj_r + 2'd1;
        end
      end
      mlp_pkg::ST_SEG: begin
        a_r <= a_new;
        k_r <= k_new;
        neg_r <= s_r[VW-1];
        r_r <= s_r[VW-1] ? -VW'(ONE) : VW'(ONE);
      end
      mlp_pkg::ST_ACT1: begin
        if (mul_done) begin
          r_r <= sat_f(SW'(pr) + SW'(C2F[k_r]));
        end
      end
      mlp_pkg::ST_ACT2: begin
        if (mul_done) begin
          r_r <= neg_r ? -poly_val : poly_val;
        end
      end
      mlp_pkg::ST_OUT: begin
        if (mul_done) begin
          acc_r <= sat_f(SW'(acc_r) + SW'(pr));
          if (ni_r != 5'(LASTN)) begin
            ni_r <= ni_r + 5'd1;
            s_r <= VW'(BHF[ni_r + 5'd1]);
          end
        end
      end
      mlp_pkg::ST_FINAL: begin
        if (mul_done) begin
          y_r <= y_clamp;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_predicted_value = out_val_r;

`ifndef SYNTHESIS
  a_done_while_run: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> run_r)
    else $error("multiplier finished without a pending product");
  a_neuron_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mlp_pkg::ST_HID |-> ni_r <= 5'(LASTN))
    else $error("neuron index beyond the last neuron");
  a_result_posted: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mlp_pkg::ST_DONE && !(out_valid_r && out_stall) |=> out_valid_r)
    else $error("finished result was not posted");
  a_no_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mlp_pkg::ST_IDLE |-> !run_r)
    else $error("multiplier busy while the sequencer is idle");
`endif

endmodule

`default_nettype wire
